[hw/rtl/ogn_pkg.sv]
// Shared types, widths and codes for the onset gate and normalizer.
package ogn_pkg;

  // Gate ring size and derived index widths
  localparam int GATE_SLOTS = 8;
  localparam int SLOT_IDX_W = (GATE_SLOTS > 1) ? $clog2(GATE_SLOTS) : 1;

  // Shift-add multiply and restoring divide both take one bit per cycle
  localparam int STEPS   = 16;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int CNT_W   = (SLOT_IDX_W > STEP_W) ? SLOT_IDX_W : STEP_W;

  // Field widths
  localparam int EVT_W      = 32;
  localparam int LEVEL_W    = 24;
  localparam int NORM_W     = 16;
  localparam int US_W       = 20;
  localparam int DECAY_W    = 16;
  localparam int PROD_W     = LEVEL_W + DECAY_W;
  localparam int DIVISOR_W  = LEVEL_W + 1;
  localparam int TIME_W     = EVT_W + 2;    // signed gate and window bounds
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Register reset values
  localparam logic [US_W-1:0]    GATE_LEAD_RST   = 20'd20000;
  localparam logic [US_W-1:0]    GATE_TRAIL_RST  = 20'd60000;
  localparam logic [US_W-1:0]    WINDOW_HALF_RST = 20'd21333;
  localparam logic [DECAY_W-1:0] PEAK_DECAY_RST  = 16'd65000;

  // Request kinds
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_CLICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_LEAD,
    CFG_GATE_TRAIL,
    CFG_WINDOW_HALF,
    CFG_PEAK_DECAY
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_PEAK,
    ST_DIV,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic               command;
    logic [EVT_W-1:0]   event_time;
    logic [LEVEL_W-1:0] onset_level;
  } ogn_in_t;

  typedef struct packed {
    logic              gated;
    logic [NORM_W-1:0] normalized;
  } ogn_out_t;

endpackage

[hw/rtl/onset_gate_and_normalizer.sv]
// Top level: click gate ring, serial peak follower and serial normalizing divider.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_stall  | ogn_in_t: command, event_time, level
//  out_    | output    | out_valid/out_stall| ogn_out_t: gated, normalized
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_data
//
// A click request leaves the block idle, so it is ready again the next cycle.
// A frame scans the gate ring slot by slot (up to GATE_SLOTS slots) and stops
// at the first hit; if not gated, it then runs the shift-add decay, one peak
// update and the restoring division (one quotient bit per cycle), then loads
// the output register in the send state. A gated frame goes from the scan
// straight to the send state; the next request is taken once the block is idle.
// Synchronous active-low reset clears slot valid bits, the ring pointer, the
// running peak and the registers to their defaults. The output register lets
// a new request in while a result waits; a frame only holds in its last cycle
// while out_stall keeps a previous result in place.
module onset_gate_and_normalizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ogn_pkg::ogn_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ogn_pkg::ogn_out_t                 out_data,
  input  logic                              cfg_wr_en,
  input  logic [ogn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ogn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic [ogn_pkg::US_W-1:0]    lead_r, lead_nxt;
  logic [ogn_pkg::US_W-1:0]    trail_r, trail_nxt;
  logic [ogn_pkg::US_W-1:0]    whalf_r, whalf_nxt;
  logic [ogn_pkg::DECAY_W-1:0] decay_r, decay_nxt;

  // Gate ring
  logic signed [ogn_pkg::TIME_W-1:0] slot_open_r  [ogn_pkg::GATE_SLOTS];
  logic signed [ogn_pkg::TIME_W-1:0] slot_close_r [ogn_pkg::GATE_SLOTS];
  logic [ogn_pkg::GATE_SLOTS-1:0]    slot_valid_r, slot_valid_nxt;
  logic [ogn_pkg::SLOT_IDX_W-1:0]    slot_ptr_r, slot_ptr_nxt;

  // Control
  ogn_pkg::state_t               state_r, state_nxt;
  logic [ogn_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ogn_pkg::LEVEL_W-1:0]   peak_r, peak_nxt;

  // Datapath
  logic signed [ogn_pkg::TIME_W-1:0] wstart_r, wstart_nxt;
  logic signed [ogn_pkg::TIME_W-1:0] wend_r, wend_nxt;
  logic [ogn_pkg::LEVEL_W-1:0]       level_r, level_nxt;
  logic [ogn_pkg::DECAY_W-1:0]       dshift_r, dshift_nxt;
  logic [ogn_pkg::PROD_W-1:0]        acc_r, acc_nxt;
  logic [ogn_pkg::DIVISOR_W-1:0]     div_r, div_nxt;
  logic [ogn_pkg::LEVEL_W-1:0]       rem_r, rem_nxt;
  logic [ogn_pkg::NORM_W-1:0]        quo_r, quo_nxt;
  logic                              gated_r, gated_nxt;
  ogn_pkg::ogn_out_t                 out_data_r, out_data_nxt;

  // Request decode
  logic                              in_acc;
  logic                              click_acc;
  logic signed [ogn_pkg::TIME_W-1:0] t_s;
  logic signed [ogn_pkg::TIME_W-1:0] click_open;
  logic signed [ogn_pkg::TIME_W-1:0] click_close;

  // Per-cycle helpers
  logic [ogn_pkg::SLOT_IDX_W-1:0]    scan_idx;
  logic                              slot_hit;
  logic [ogn_pkg::PROD_W:0]          mul_sum;
  logic [ogn_pkg::LEVEL_W-1:0]       decayed;
  logic [ogn_pkg::LEVEL_W-1:0]       new_peak;
  logic [ogn_pkg::DIVISOR_W-1:0]     rem_shift;
  logic                              quo_bit;
  logic                              out_free;

  assign in_stall  = (state_r != ogn_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign click_acc = in_acc && (in_data.command == ogn_pkg::CMD_CLICK);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Signed gate bounds of a click
  assign t_s         = {2'b00, in_data.event_time};
  assign click_open  = t_s - $signed({{(ogn_pkg::TIME_W-ogn_pkg::US_W){1'b0}}, lead_r});
  assign click_close = t_s + $signed({{(ogn_pkg::TIME_W-ogn_pkg::US_W){1'b0}}, trail_r});

  // One slot checked per scan cycle
  assign scan_idx = cnt_r[ogn_pkg::SLOT_IDX_W-1:0];
  assign slot_hit = slot_valid_r[scan_idx] &&
                    (wend_r > slot_open_r[scan_idx]) &&
                    (wstart_r < slot_close_r[scan_idx]);

  // Shift-add multiply step, LSB of decay first
  assign mul_sum = {1'b0, acc_r} +
                   (dshift_r[0] ? {1'b0, peak_r, {ogn_pkg::DECAY_W{1'b0}}}
                                : {(ogn_pkg::PROD_W+1){1'b0}});

  // Peak follower
  assign decayed  = acc_r[ogn_pkg::PROD_W-1:ogn_pkg::DECAY_W];
  assign new_peak = (level_r > decayed) ? level_r : decayed;

  // Restoring divide step
  assign rem_shift = {rem_r, 1'b0};
  assign quo_bit   = (rem_shift >= div_r);

  // Next state and datapath
  always_comb begin
    lead_nxt       = lead_r;
    trail_nxt      = trail_r;
    whalf_nxt      = whalf_r;
    decay_nxt      = decay_r;
    slot_valid_nxt = slot_valid_r;
    slot_ptr_nxt   = slot_ptr_r;
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    peak_nxt       = peak_r;
    wstart_nxt     = wstart_r;
    wend_nxt       = wend_r;
    level_nxt      = level_r;
    dshift_nxt     = dshift_r;
    acc_nxt        = acc_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    gated_nxt      = gated_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;

    // Register writes
    if (cfg_wr_en) begin
      case (cfg_index)
        ogn_pkg::CFG_GATE_LEAD:   lead_nxt  = cfg_data[ogn_pkg::US_W-1:0];
        ogn_pkg::CFG_GATE_TRAIL:  trail_nxt = cfg_data[ogn_pkg::US_W-1:0];
        ogn_pkg::CFG_WINDOW_HALF: whalf_nxt = cfg_data[ogn_pkg::US_W-1:0];
        ogn_pkg::CFG_PEAK_DECAY:  decay_nxt = cfg_data[ogn_pkg::DECAY_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ogn_pkg::ST_IDLE: begin
        if (click_acc) begin
          slot_valid_nxt[slot_ptr_r] = 1'b1;
          if (slot_ptr_r == ogn_pkg::SLOT_IDX_W'(ogn_pkg::GATE_SLOTS - 1)) begin
            slot_ptr_nxt = '0;
          end else begin
            slot_ptr_nxt = slot_ptr_r + 1'b1;
          end
        end else if (in_acc) begin
          wstart_nxt = t_s - $signed({{(ogn_pkg::TIME_W-ogn_pkg::US_W){1'b0}}, whalf_r});
          wend_nxt   = t_s + $signed({{(ogn_pkg::TIME_W-ogn_pkg::US_W){1'b0}}, whalf_r});
          level_nxt  = in_data.onset_level;
          dshift_nxt = decay_r;
          acc_nxt    = '0;
          quo_nxt    = '0;
          gated_nxt  = 1'b0;
          cnt_nxt    = '0;
          state_nxt  = ogn_pkg::ST_SCAN;
        end
      end
      ogn_pkg::ST_SCAN: begin
        if (slot_hit) begin
          gated_nxt = 1'b1;
          state_nxt = ogn_pkg::ST_SEND;
        end else if (cnt_r == ogn_pkg::CNT_W'(ogn_pkg::GATE_SLOTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ogn_pkg::ST_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ogn_pkg::ST_MUL: begin
        acc_nxt    = mul_sum[ogn_pkg::PROD_W:1];
        dshift_nxt = dshift_r >> 1;
        if (cnt_r == ogn_pkg::CNT_W'(ogn_pkg::STEPS - 1)) begin
          state_nxt = ogn_pkg::ST_PEAK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ogn_pkg::ST_PEAK: begin
        peak_nxt  = new_peak;
        div_nxt   = {1'b0, new_peak} + ogn_pkg::DIVISOR_W'(1);
        rem_nxt   = level_r;
        cnt_nxt   = '0;
        state_nxt = ogn_pkg::ST_DIV;
      end
      ogn_pkg::ST_DIV: begin
        // remainder stays below the divisor, so it fits the level width
        if (quo_bit) begin
          rem_nxt = ogn_pkg::LEVEL_W'(rem_shift - div_r);
        end else begin
          rem_nxt = rem_shift[ogn_pkg::LEVEL_W-1:0];
        end
        quo_nxt = {quo_r[ogn_pkg::NORM_W-2:0], quo_bit};
        if (cnt_r == ogn_pkg::CNT_W'(ogn_pkg::STEPS - 1)) begin
          state_nxt = ogn_pkg::ST_SEND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ogn_pkg::ST_SEND: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.gated      = gated_r;
          out_data_nxt.normalized = quo_r;
          state_nxt               = ogn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ogn_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r       <= ogn_pkg::GATE_LEAD_RST;
      trail_r      <= ogn_pkg::GATE_TRAIL_RST;
      whalf_r      <= ogn_pkg::WINDOW_HALF_RST;
      decay_r      <= ogn_pkg::PEAK_DECAY_RST;
      slot_valid_r <= '0;
      slot_ptr_r   <= '0;
      state_r      <= ogn_pkg::ST_IDLE;
      cnt_r        <= '0;
      peak_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      lead_r       <= lead_nxt;
      trail_r      <= trail_nxt;
      whalf_r      <= whalf_nxt;
      decay_r      <= decay_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_ptr_r   <= slot_ptr_nxt;
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      peak_r       <= peak_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wstart_r   <= wstart_nxt;
    wend_r     <= wend_nxt;
    level_r    <= level_nxt;
    dshift_r   <= dshift_nxt;
    acc_r      <= acc_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    gated_r    <= gated_nxt;
    out_data_r <= out_data_nxt;
  end

  // Gate bound store, written on a click
  always_ff @(posedge clk) begin
    if (click_acc) begin
      slot_open_r[slot_ptr_r]  <= click_open;
      slot_close_r[slot_ptr_r] <= click_close;
    end
  end

endmodule

[hw/rtl/ogn_checker.sv]
// Port-level checker for the onset gate and normalizer, bound to the top level.
module ogn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input ogn_pkg::ogn_in_t               in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input ogn_pkg::ogn_out_t              out_data
);

  // A frame request occupies the block for the following cycles
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == ogn_pkg::CMD_FRAME) |=> in_stall)
    else $error("frame request did not occupy the block");

  // A click request leaves the input unstalled for the next request
  a_click_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == ogn_pkg::CMD_CLICK) |=> !in_stall)
    else $error("click request held the input");

  // A gated result carries no level
  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gated |-> (out_data.normalized == '0))
    else $error("gated result with nonzero level");

  // A new result appears only as a frame finishes
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a frame in progress");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind onset_gate_and_normalizer ogn_checker u_ogn_checker (.*);
